// ----- design/spi_fram_chunked_access_sequencer_assert.svh -----
// ----------------------------------------------------------------------------
// SPI FRAM chunked access sequencer: assertion macros
// Implication checks sampled on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SPI_FRAM_CHUNKED_ACCESS_SEQUENCER_ASSERT_SVH
`define SPI_FRAM_CHUNKED_ACCESS_SEQUENCER_ASSERT_SVH

// same-cycle implication
`define SFCAS_ASSERT_NOW(lbl, ante, cons, msg) \
lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SFCAS_ASSERT_NXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/sfcas_pkg.sv -----
// ----------------------------------------------------------------------------
// sfcas_pkg
// Types and constants shared by the SPI FRAM chunked access sequencer.
// ----------------------------------------------------------------------------
package sfcas_pkg;

    localparam int MODE_W = 2;
    localparam int ADDR_W = 24;
    localparam int LEN_W  = 16;
    localparam int OP_W   = 3;
    localparam int BYTE_W = 8;

    localparam logic [MODE_W-1:0] MODE_START_RD = 2'd0;
    localparam logic [MODE_W-1:0] MODE_START_WR = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TICK     = 2'd2;

    localparam logic [BYTE_W-1:0] CMD_WREN  = 8'h06;
    localparam logic [BYTE_W-1:0] CMD_READ  = 8'h03;
    localparam logic [BYTE_W-1:0] CMD_WRITE = 8'h02;
    localparam logic [BYTE_W-1:0] BYTE_MASK = 8'hFF;

    typedef enum logic [OP_W-1:0] {
        OP_SEL     = 3'd0,
        OP_DESEL   = 3'd1,
        OP_LIT     = 3'd2,
        OP_SENDBUF = 3'd3,
        OP_RECVBUF = 3'd4,
        OP_DONE    = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        CMDQ_START_RD,
        CMDQ_START_WR,
        CMDQ_TICK
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_IDLE,
        KIND_READ,
        KIND_WRITE
    } t_kind;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WEN_SEL,
        ST_WEN_CMD,
        ST_WEN_DESEL,
        ST_SEL,
        ST_CMD,
        ST_ADDR_HI,
        ST_ADDR_MID,
        ST_ADDR_LO,
        ST_DATA,
        ST_DESEL,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_cmd              cmd;
        logic [ADDR_W-1:0] address;
        logic [LEN_W-1:0]  length;
    } t_qent;

    typedef struct packed {
        logic  valid;
        t_qent ent;
    } t_push;

    typedef struct packed {
        logic  valid;
        t_qent ent;
    } t_head;

endpackage

// ----- design/sfcas_ifs.sv -----
// ----------------------------------------------------------------------------
// sfcas request and response channels
// Valid/ready channels for request beats and bus operation beats.
// ----------------------------------------------------------------------------
interface sfcas_req_if import sfcas_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [ADDR_W-1:0] address;
    logic [LEN_W-1:0]  length;

    modport source (output valid, output mode, output address, output length, input ready);
    modport sink   (input valid, input mode, input address, input length, output ready);
endinterface

interface sfcas_rsp_if import sfcas_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] byte_value;
    logic [LEN_W-1:0]  buffer_index;
    logic              last;

    modport source (output valid, output op, output byte_value, output buffer_index,
                    output last, input ready);
    modport sink   (input valid, input op, input byte_value, input buffer_index,
                    input last, output ready);
endinterface

// ----- design/sfcas_front.sv -----
// ----------------------------------------------------------------------------
// sfcas_front
// Accepts request beats, decodes the mode and drops undefined modes.
// ----------------------------------------------------------------------------
module sfcas_front import sfcas_pkg::*; (
    sfcas_req_if.sink i_req,
    input  logic      i_q_full,
    output t_push     o_push
);

    logic accept;

    assign i_req.ready = !i_q_full;
    assign accept      = i_req.valid && !i_q_full;

    always_comb begin
        o_push.valid       = 1'b0;
        o_push.ent.cmd     = CMDQ_TICK;
        o_push.ent.address = i_req.address;
        o_push.ent.length  = i_req.length;
        unique case (i_req.mode)
            MODE_START_RD: begin
                o_push.valid   = accept;
                o_push.ent.cmd = CMDQ_START_RD;
            end
            MODE_START_WR: begin
                o_push.valid   = accept;
                o_push.ent.cmd = CMDQ_START_WR;
            end
            MODE_TICK: begin
                o_push.valid   = accept;
                o_push.ent.cmd = CMDQ_TICK;
            end
            default: begin
                o_push.valid = 1'b0;
            end
        endcase
    end

endmodule

// ----- design/sfcas_queue.sv -----
// ----------------------------------------------------------------------------
// sfcas_queue
// Two-entry command queue between the front decoder and the sequencer.
// ----------------------------------------------------------------------------
module sfcas_queue import sfcas_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    input  logic  i_pop,
    output logic  o_full,
    output t_head o_head
);

    t_qent      r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       do_push;
    logic       do_pop;

    assign o_full       = (r_count == 2'd2);
    assign do_push      = i_push.valid && !o_full;
    assign do_pop       = i_pop && (r_count != 2'd0);
    assign o_head.valid = (r_count != 2'd0);
    assign o_head.ent   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 2'd1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

// ----- design/sfcas_back.sv -----
// ----------------------------------------------------------------------------
// sfcas_back
// Holds the access state and walks one chunk of bus operations per tick.
// ----------------------------------------------------------------------------
module sfcas_back import sfcas_pkg::*; #(
    parameter int CHUNK_BYTES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_head       i_head,
    output logic        o_pop,
    sfcas_rsp_if.source o_rsp
);

    localparam int CW = $clog2(CHUNK_BYTES) + 1;

    t_state            r_state;
    t_state            n_state;
    t_kind             r_kind;
    logic [ADDR_W-1:0] r_addr;
    logic [LEN_W-1:0]  r_len;
    logic [LEN_W-1:0]  r_idx;
    logic [CW-1:0]     r_cnt;

    logic              r_out_valid;
    t_op               r_out_op;
    logic [BYTE_W-1:0] r_out_byte;
    logic [LEN_W-1:0]  r_out_idx;
    logic              r_out_last;

    logic              advance;
    logic              emit;
    t_op               emit_op;
    logic [BYTE_W-1:0] emit_byte;
    logic [LEN_W-1:0]  emit_idx;
    logic              emit_last;
    logic              more_in_chunk;
    logic              data_left;

    assign advance       = !r_out_valid || o_rsp.ready;
    assign o_pop         = (r_state == ST_IDLE) && i_head.valid;
    assign data_left     = (r_idx < r_len);
    assign more_in_chunk = ((r_cnt + CW'(1)) < CW'(CHUNK_BYTES))
                           && (({1'b0, r_idx} + 17'd1) < {1'b0, r_len});

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.op           = r_out_op;
    assign o_rsp.byte_value   = r_out_byte;
    assign o_rsp.buffer_index = r_out_idx;
    assign o_rsp.last         = r_out_last;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_head.valid && i_head.ent.cmd == CMDQ_TICK) begin
                    if (r_kind == KIND_WRITE) begin
                        n_state = ST_WEN_SEL;
                    end else if (r_kind == KIND_READ) begin
                        n_state = ST_SEL;
                    end
                end
            end
            ST_WEN_SEL:   if (advance) n_state = ST_WEN_CMD;
            ST_WEN_CMD:   if (advance) n_state = ST_WEN_DESEL;
            ST_WEN_DESEL: if (advance) n_state = ST_SEL;
            ST_SEL:       if (advance) n_state = ST_CMD;
            ST_CMD:       if (advance) n_state = ST_ADDR_HI;
            ST_ADDR_HI:   if (advance) n_state = ST_ADDR_MID;
            ST_ADDR_MID:  if (advance) n_state = ST_ADDR_LO;
            ST_ADDR_LO: begin
                if (advance) begin
                    n_state = data_left ? ST_DATA : ST_DESEL;
                end
            end
            ST_DATA: begin
                if (advance && !more_in_chunk) begin
                    n_state = ST_DESEL;
                end
            end
            ST_DESEL: begin
                if (advance) begin
                    n_state = data_left ? ST_IDLE : ST_DONE;
                end
            end
            ST_DONE:      if (advance) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        emit      = 1'b1;
        emit_op   = OP_SEL;
        emit_byte = '0;
        emit_idx  = '0;
        emit_last = 1'b0;
        unique case (r_state)
            ST_IDLE:      emit = 1'b0;
            ST_WEN_SEL:   emit_op = OP_SEL;
            ST_WEN_CMD: begin
                emit_op   = OP_LIT;
                emit_byte = CMD_WREN;
            end
            ST_WEN_DESEL: emit_op = OP_DESEL;
            ST_SEL:       emit_op = OP_SEL;
            ST_CMD: begin
                emit_op   = OP_LIT;
                emit_byte = (r_kind == KIND_WRITE) ? CMD_WRITE : CMD_READ;
            end
            ST_ADDR_HI: begin
                emit_op   = OP_LIT;
                emit_byte = r_addr[23:16] & BYTE_MASK;
            end
            ST_ADDR_MID: begin
                emit_op   = OP_LIT;
                emit_byte = r_addr[15:8] & BYTE_MASK;
            end
            ST_ADDR_LO: begin
                emit_op   = OP_LIT;
                emit_byte = r_addr[7:0] & BYTE_MASK;
            end
            ST_DATA: begin
                emit_op  = (r_kind == KIND_WRITE) ? OP_SENDBUF : OP_RECVBUF;
                emit_idx = r_idx;
            end
            ST_DESEL: begin
                emit_op   = OP_DESEL;
                emit_last = data_left;
            end
            ST_DONE: begin
                emit_op   = OP_DONE;
                emit_last = 1'b1;
            end
            default:      emit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_kind      <= KIND_IDLE;
            r_addr      <= '0;
            r_len       <= '0;
            r_idx       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (advance) begin
                r_out_valid <= emit;
            end
            if (o_pop && r_kind == KIND_IDLE && i_head.ent.cmd != CMDQ_TICK) begin
                r_addr <= i_head.ent.address;
                r_len  <= i_head.ent.length;
                r_idx  <= '0;
                r_kind <= (i_head.ent.cmd == CMDQ_START_RD) ? KIND_READ : KIND_WRITE;
            end
            if (r_state == ST_SEL) begin
                r_cnt <= '0;
            end
            if (r_state == ST_DATA && advance) begin
                r_idx  <= r_idx + LEN_W'(1);
                r_addr <= r_addr + ADDR_W'(1);
                r_cnt  <= r_cnt + CW'(1);
            end
            if (r_state == ST_DONE && advance) begin
                r_kind <= KIND_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_out_op   <= emit_op;
            r_out_byte <= emit_byte;
            r_out_idx  <= emit_idx;
            r_out_last <= emit_last;
        end
    end

endmodule

// ----- design/spi_fram_chunked_access_sequencer.sv -----
// ----------------------------------------------------------------------------
// spi_fram_chunked_access_sequencer
// Turns start requests and service ticks into SPI FRAM bus operation beats.
// ----------------------------------------------------------------------------
//  channel  dir  beat
//  i_req    in   mode, address, length
//  o_rsp    out  op, byte_value, buffer_index, last
//
//  A start request gives no beat and is taken by the sequencer while idle.
//  A tick gives up to 10 + CHUNK_BYTES beats, one per cycle while o_rsp
//  is ready, from the output register of the sequencer.
//  Up to two requests wait in the queue while the sequencer is busy.
//  A stall on o_rsp holds the sequencer; reset (i_rst_n low) empties all.
// ----------------------------------------------------------------------------
`include "spi_fram_chunked_access_sequencer_assert.svh"

module spi_fram_chunked_access_sequencer import sfcas_pkg::*; #(
    parameter int CHUNK_BYTES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sfcas_req_if.sink   i_req,
    sfcas_rsp_if.source o_rsp
);

    t_push push;
    t_head head;
    logic  q_full;
    logic  pop;

    sfcas_front u_front (
        .i_req    (i_req),
        .i_q_full (q_full),
        .o_push   (push)
    );

    sfcas_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_head  (head)
    );

    sfcas_back #(
        .CHUNK_BYTES (CHUNK_BYTES)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_rsp   (o_rsp)
    );

    `SFCAS_ASSERT_NOW(a_done_is_last, o_rsp.valid && o_rsp.op == OP_DONE, o_rsp.last, "done beat not last")
    `SFCAS_ASSERT_NOW(a_byte_only_lit, o_rsp.valid && o_rsp.op != OP_LIT, o_rsp.byte_value == 8'd0, "byte set off literal")
    `SFCAS_ASSERT_NOW(a_idx_only_data, o_rsp.valid && o_rsp.op != OP_SENDBUF && o_rsp.op != OP_RECVBUF, o_rsp.buffer_index == 16'd0, "index set off data")
    `SFCAS_ASSERT_NXT(a_done_then_sel, o_rsp.valid && o_rsp.ready && o_rsp.last && o_rsp.op == OP_DESEL, !o_rsp.valid || o_rsp.op == OP_SEL, "beat after chunk end")

endmodule

// ----- bench/sfcas_beat_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI FRAM chunked access sequencer: bus operation beat checker
// Watches the request and response channels, predicts the bus operation
// beats of every accepted request and compares each response beat, field
// by field, with the oldest predicted beat.
// ----------------------------------------------------------------------------
module sfcas_beat_checker import sfcas_pkg::*; #(
    parameter int CHUNK_BYTES = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    sfcas_req_if i_req,
    sfcas_rsp_if i_rsp,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct packed {
        t_op               op;
        logic [BYTE_W-1:0] byte_value;
        logic [LEN_W-1:0]  buffer_index;
        logic              last;
    } t_bus_beat;

    t_bus_beat         bus_beat_q[$];
    t_kind             xfer_kind;
    logic [ADDR_W-1:0] xfer_addr;
    logic [LEN_W-1:0]  xfer_len;
    logic [LEN_W-1:0]  xfer_idx;

    function automatic void queue_beat(t_op op, logic [BYTE_W-1:0] value,
                                       logic [LEN_W-1:0] index);
        t_bus_beat b;
        b.op           = op;
        b.byte_value   = value;
        b.buffer_index = index;
        b.last         = 1'b0;
        bus_beat_q.push_back(b);
    endfunction

    function automatic void queue_frame_head(logic [BYTE_W-1:0] cmd);
        queue_beat(OP_SEL, '0, '0);
        queue_beat(OP_LIT, cmd, '0);
        queue_beat(OP_LIT, xfer_addr[23:16], '0);
        queue_beat(OP_LIT, xfer_addr[15:8], '0);
        queue_beat(OP_LIT, xfer_addr[7:0], '0);
    endfunction

    function automatic void predict_chunk_beats(logic [MODE_W-1:0] mode,
                                                logic [ADDR_W-1:0] address,
                                                logic [LEN_W-1:0]  length);
        t_op data_op;
        int  n;
        if (mode == MODE_START_RD || mode == MODE_START_WR) begin
            if (xfer_kind == KIND_IDLE) begin
                xfer_addr = address;
                xfer_len  = length;
                xfer_idx  = '0;
                xfer_kind = (mode == MODE_START_RD) ? KIND_READ : KIND_WRITE;
            end
            return;
        end
        if (mode != MODE_TICK || xfer_kind == KIND_IDLE) return;
        if (xfer_kind == KIND_WRITE) begin
            queue_beat(OP_SEL, '0, '0);
            queue_beat(OP_LIT, CMD_WREN, '0);
            queue_beat(OP_DESEL, '0, '0);
            queue_frame_head(CMD_WRITE);
            data_op = OP_SENDBUF;
        end else begin
            queue_frame_head(CMD_READ);
            data_op = OP_RECVBUF;
        end
        n = 0;
        while (n < CHUNK_BYTES && xfer_idx < xfer_len) begin
            queue_beat(data_op, '0, xfer_idx);
            xfer_idx++;
            xfer_addr++;
            n++;
        end
        queue_beat(OP_DESEL, '0, '0);
        if (xfer_idx >= xfer_len) begin
            xfer_kind = KIND_IDLE;
            queue_beat(OP_DONE, '0, '0);
        end
        bus_beat_q[bus_beat_q.size() - 1].last = 1'b1;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            o_fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_bus_beat want;
        if (!i_rst_n) begin
            bus_beat_q.delete();
            xfer_kind = KIND_IDLE;
            xfer_addr = '0;
            xfer_len  = '0;
            xfer_idx  = '0;
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (bus_beat_q.size() == 0) begin
                    $error("unexpected beat: op %0d byte_value 0x%02h buffer_index %0d last %0b",
                           i_rsp.op, i_rsp.byte_value, i_rsp.buffer_index, i_rsp.last);
                    o_fail_count++;
                end else begin
                    want = bus_beat_q.pop_front();
                    check_field("op", 32'(want.op), 32'(i_rsp.op));
                    check_field("byte_value", 32'(want.byte_value), 32'(i_rsp.byte_value));
                    check_field("buffer_index", 32'(want.buffer_index),
                                32'(i_rsp.buffer_index));
                    check_field("last", 32'(want.last), 32'(i_rsp.last));
                end
            end
            if (i_req.valid && i_req.ready)
                predict_chunk_beats(i_req.mode, i_req.address, i_req.length);
        end
        o_pending <= bus_beat_q.size();
    end

endmodule

// ----- bench/spi_fram_chunked_access_sequencer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI FRAM chunked access sequencer: testbench top
// Drives directed and random start, tick and undefined-mode requests
// through three idling phases and a long response hold-off, then gives
// the verdict from the beat checker.
// ----------------------------------------------------------------------------
module spi_fram_chunked_access_sequencer_tb;
    import sfcas_pkg::*;

    localparam int                CHUNK_BYTES     = 16;
    localparam logic [MODE_W-1:0] MODE_UNDEF      = 2'd3;
    localparam int                HOLD_OFF_CYCLES = 300;
    localparam int                DRAIN_CYCLES    = 60;
    localparam int                WATCHDOG_LIMIT  = 5000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   tx_idle_pct;
    int   rx_idle_pct;
    int   hold_off_count;

    sfcas_req_if req_ch ();
    sfcas_rsp_if rsp_ch ();

    spi_fram_chunked_access_sequencer #(
        .CHUNK_BYTES(CHUNK_BYTES)
    ) u_dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch)
    );

    sfcas_beat_checker #(
        .CHUNK_BYTES(CHUNK_BYTES)
    ) u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req       (req_ch),
        .i_rsp       (rsp_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int ticks_for(logic [LEN_W-1:0] length);
        return (length == 0) ? 1 : (int'(length) + CHUNK_BYTES - 1) / CHUNK_BYTES;
    endfunction

    task automatic send_request(logic [MODE_W-1:0] mode, logic [ADDR_W-1:0] address,
                                logic [LEN_W-1:0] length);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.mode    <= mode;
        req_ch.address <= address;
        req_ch.length  <= length;
        do @(posedge clk); while (!req_ch.ready);
    endtask

    task automatic run_transfer(logic [MODE_W-1:0] mode, logic [ADDR_W-1:0] address,
                                logic [LEN_W-1:0] length, int tick_count, bit add_noise);
        send_request(mode, address, length);
        for (int t = 0; t < tick_count; t++) begin
            if (add_noise && $urandom_range(0, 5) == 0)
                send_request($urandom_range(0, 1) ? MODE_START_WR : MODE_START_RD,
                             ADDR_W'($urandom), LEN_W'($urandom_range(0, 255)));
            if (add_noise && $urandom_range(0, 7) == 0)
                send_request(MODE_UNDEF, ADDR_W'($urandom), LEN_W'($urandom));
            send_request(MODE_TICK, ADDR_W'($urandom), LEN_W'($urandom));
        end
    endtask

    task automatic run_random(int item_goal);
        int                sent;
        int                pick;
        int                n_ticks;
        logic [MODE_W-1:0] start_mode;
        logic [ADDR_W-1:0] address;
        logic [LEN_W-1:0]  length;
        sent = 0;
        while (sent < item_goal) begin
            pick       = $urandom_range(0, 99);
            start_mode = $urandom_range(0, 1) ? MODE_START_WR : MODE_START_RD;
            address    = ($urandom_range(0, 7) == 0)
                         ? ADDR_W'(24'hFFFFFF - $urandom_range(0, 40))
                         : ADDR_W'($urandom);
            length     = ($urandom_range(0, 9) == 0) ? LEN_W'($urandom_range(0, 255))
                                                     : LEN_W'($urandom_range(0, 48));
            n_ticks    = ticks_for(length);
            if (pick < 80) begin
                run_transfer(start_mode, address, length, n_ticks, 1'b1);
                sent += n_ticks + 1;
            end else if (pick < 90) begin
                send_request($urandom_range(0, 1) ? MODE_UNDEF : MODE_TICK,
                             ADDR_W'($urandom), LEN_W'($urandom));
            end else begin
                run_transfer(start_mode, address, length, $urandom_range(0, n_ticks - 1), 1'b0);
                sent += 1;
            end
        end
    endtask

    initial begin
        int held;
        held = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_off_count != held) begin
                held = hold_off_count;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end else begin
                rsp_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    initial begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin
        tx_idle_pct    = 10;
        rx_idle_pct    = 70;
        hold_off_count = 0;
        rst_n          <= 1'b0;
        req_ch.valid   <= 1'b0;
        req_ch.mode    <= '0;
        req_ch.address <= '0;
        req_ch.length  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        send_request(MODE_TICK, '1, '1);
        send_request(MODE_UNDEF, '1, '1);
        run_transfer(MODE_START_RD, '0, '0, 1, 1'b0);
        run_transfer(MODE_START_WR, '1, '0, 1, 1'b0);
        run_transfer(MODE_START_RD, 24'hFFFFF8, 16'd20, 2, 1'b0);
        run_transfer(MODE_START_WR, 24'h123456, 16'd16, 1, 1'b0);
        send_request(MODE_START_WR, 24'hA5A5A5, 16'd17);
        send_request(MODE_START_RD, 24'h5A5A5A, 16'hFFFF);
        send_request(MODE_TICK, '0, '0);
        send_request(MODE_TICK, '0, '0);
        run_transfer(MODE_START_RD, 24'h5A5A5A, 16'd1, 1, 1'b0);
        send_request(MODE_TICK, '0, '0);
        send_request(MODE_START_RD, 24'hABCDEF, 16'd33);
        send_request(MODE_UNDEF, '0, '0);
        repeat (3) send_request(MODE_TICK, '0, '0);
        run_random(70);

        tx_idle_pct = 70;
        rx_idle_pct = 10;
        run_random(70);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_off_count <= hold_off_count + 1;
        run_random(70);

        // flush any unfinished transfer, then move a long buffer range
        repeat (CHUNK_BYTES + 1) send_request(MODE_TICK, '0, '0);
        run_transfer(MODE_START_WR, ADDR_W'($urandom), 16'd200, ticks_for(16'd200), 1'b0);

        req_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
